// ===== rtl/itoa_fmt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_fmt_pkg
// Shared types, codes and helpers for the integer to ascii formatter.
// ----------------------------------------------------------------------------
package itoa_fmt_pkg;

  localparam int VAL_W      = 64;
  localparam int NUM_DIGITS = 20;
  localparam int DIG_W      = 4 * NUM_DIGITS;
  localparam int BITCNT_W   = 6;
  localparam int DIGCNT_W   = 5;
  localparam int FWIDTH_W   = 6;

  localparam logic [1:0] KIND_UDEC  = 2'd0;
  localparam logic [1:0] KIND_SDEC  = 2'd1;
  localparam logic [1:0] KIND_HEXLO = 2'd2;
  localparam logic [1:0] KIND_HEXUP = 2'd3;

  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_MINUS = 8'h2d;
  localparam logic [7:0] CHR_UP_A  = 8'h41;
  localparam logic [7:0] CHR_LO_A  = 8'h61;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_SIGN,
    ST_PAD,
    ST_DIG
  } fmt_state_t;

  // ascii for one digit nibble
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    begin
      base = upper ? CHR_UP_A : CHR_LO_A;
      if (d < 4'd10) begin
        digit_char = CHR_ZERO + {4'd0, d};
      end else begin
        digit_char = base + {4'd0, d - 4'd10};
      end
    end
  endfunction

endpackage

// ===== rtl/integer_to_ascii_formatter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core
// Formats a 64-bit operand as decimal or hex ascii, one character at a time.
// ----------------------------------------------------------------------------
// A word is taken on a rising edge with start high and busy low: kind, value,
// minimum field width and zero pad flag. The characters come out most
// significant first on out_char, each held for exactly one cycle with
// out_valid high; out_last marks the final character. The receiver cannot
// stall, so every strobed character is taken at the end of its cycle.
// Decimal kinds run a bit-serial double-dabble over the 64 operand bits
// (one bit per cycle into a 20-digit bcd shift register); hex kinds load the
// nibbles directly. Leading zero digits are then stripped one per cycle, up
// to 19 of them, and a final normalise step sets up the output, after which
// sign, padding and digits stream out at one character per cycle.
// busy stays high until the last character has gone out. A synchronous reset
// returns the block to idle, dropping any item in progress.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_core #(
  parameter int MAX_WIDTH = 40
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           in_req_type,
  input  logic [itoa_fmt_pkg::VAL_W-1:0]       in_value,
  input  logic [itoa_fmt_pkg::FWIDTH_W-1:0]    in_pad_width,
  input  logic                                 in_zero_pad,
  output logic                                 out_valid,
  output logic [7:0]                           out_char,
  output logic                                 out_last
);
  import itoa_fmt_pkg::*;

  localparam logic [FWIDTH_W-1:0] MAX_W = FWIDTH_W'(MAX_WIDTH);

  fmt_state_t            state_r, state_nxt;
  logic [VAL_W-1:0]      bin_r, bin_nxt;
  logic [DIG_W-1:0]      digs_r, digs_nxt;
  logic [BITCNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [DIGCNT_W-1:0]   dig_cnt_r, dig_cnt_nxt;
  logic [FWIDTH_W-1:0]   pad_cnt_r, pad_cnt_nxt;
  logic [FWIDTH_W-1:0]   width_r, width_nxt;
  logic                  neg_r, neg_nxt;
  logic                  zpad_r, zpad_nxt;
  logic                  upper_r, upper_nxt;

  logic                  in_neg;
  logic [VAL_W-1:0]      in_mag;
  logic [FWIDTH_W-1:0]   in_wsat;
  logic [DIG_W-1:0]      dd_adj;
  logic [3:0]            top_dig;
  logic [FWIDTH_W-1:0]   dig_cnt_ext;
  logic [FWIDTH_W-1:0]   pad_calc;

  assign in_neg      = (in_req_type == KIND_SDEC) && in_value[VAL_W-1];
  assign in_mag      = in_neg ? (~in_value + VAL_W'(1)) : in_value;
  assign in_wsat     = (in_pad_width > MAX_W) ? MAX_W : in_pad_width;
  assign top_dig     = digs_r[DIG_W-1 -: 4];
  assign dig_cnt_ext = FWIDTH_W'(dig_cnt_r);
  assign pad_calc    = (width_r > dig_cnt_ext) ? (width_r - dig_cnt_ext) : '0;

  // add-3 correction on every bcd digit
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (digs_r[4*i +: 4] >= 4'd5) begin
        dd_adj[4*i +: 4] = digs_r[4*i +: 4] + 4'd3;
      end else begin
        dd_adj[4*i +: 4] = digs_r[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r     <= bin_nxt;
    digs_r    <= digs_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    dig_cnt_r <= dig_cnt_nxt;
    pad_cnt_r <= pad_cnt_nxt;
    width_r   <= width_nxt;
    neg_r     <= neg_nxt;
    zpad_r    <= zpad_nxt;
    upper_r   <= upper_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    bin_nxt     = bin_r;
    digs_nxt    = digs_r;
    bit_cnt_nxt = bit_cnt_r;
    dig_cnt_nxt = dig_cnt_r;
    pad_cnt_nxt = pad_cnt_r;
    width_nxt   = width_r;
    neg_nxt     = neg_r;
    zpad_nxt    = zpad_r;
    upper_nxt   = upper_r;
    busy        = 1'b1;
    out_valid   = 1'b0;
    out_char    = CHR_ZERO;
    out_last    = 1'b0;

    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          neg_nxt     = in_neg;
          zpad_nxt    = in_zero_pad;
          upper_nxt   = (in_req_type == KIND_HEXUP);
          width_nxt   = (in_neg && in_wsat != '0) ? (in_wsat - FWIDTH_W'(1)) : in_wsat;
          dig_cnt_nxt = DIGCNT_W'(NUM_DIGITS);
          bit_cnt_nxt = '1;
          bin_nxt     = in_mag;
          if (in_req_type == KIND_HEXLO || in_req_type == KIND_HEXUP) begin
            digs_nxt  = {{(DIG_W-VAL_W){1'b0}}, in_mag};
            state_nxt = ST_NORM;
          end else begin
            digs_nxt  = '0;
            state_nxt = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        digs_nxt    = {dd_adj[DIG_W-2:0], bin_r[VAL_W-1]};
        bin_nxt     = {bin_r[VAL_W-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r - BITCNT_W'(1);
        if (bit_cnt_r == '0) begin
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        if (dig_cnt_r > DIGCNT_W'(1) && top_dig == 4'd0) begin
          digs_nxt    = {digs_r[DIG_W-5:0], 4'd0};
          dig_cnt_nxt = dig_cnt_r - DIGCNT_W'(1);
        end else begin
          pad_cnt_nxt = pad_calc;
          if (neg_r) begin
            state_nxt = ST_SIGN;
          end else if (pad_calc != '0) begin
            state_nxt = ST_PAD;
          end else begin
            state_nxt = ST_DIG;
          end
        end
      end
      ST_SIGN: begin
        out_valid = 1'b1;
        out_char  = CHR_MINUS;
        state_nxt = (pad_cnt_r != '0) ? ST_PAD : ST_DIG;
      end
      ST_PAD: begin
        out_valid   = 1'b1;
        out_char    = zpad_r ? CHR_ZERO : CHR_SPACE;
        pad_cnt_nxt = pad_cnt_r - FWIDTH_W'(1);
        if (pad_cnt_r == FWIDTH_W'(1)) begin
          state_nxt = ST_DIG;
        end
      end
      ST_DIG: begin
        out_valid   = 1'b1;
        out_char    = digit_char(top_dig, upper_r);
        out_last    = (dig_cnt_r == DIGCNT_W'(1));
        digs_nxt    = {digs_r[DIG_W-5:0], 4'd0};
        dig_cnt_nxt = dig_cnt_r - DIGCNT_W'(1);
        if (dig_cnt_r == DIGCNT_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the integer to ascii formatter core.
// ----------------------------------------------------------------------------
// Sends format requests (kind, operand, field width, pad choice) through the
// start/busy handshake and predicts the ascii characters of each word. Every
// strobed character is compared in order with the predicted one, including
// the last-character flag. A directed part hits zero, the extreme operands,
// the most negative signed value, width saturation, narrow widths and both
// pad choices; a random part follows with mixed operands, widths and sender
// gaps that land at different points of the block's work.
// ----------------------------------------------------------------------------
module testbench;
  import itoa_fmt_pkg::*;

  localparam int MAX_W          = 40;
  localparam int RANDOM_WORDS   = 410;
  localparam int CALM_WORDS     = 60;
  localparam int TAIL_CYCLES    = 130;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } fmt_char_t;

  class format_checker;
    fmt_char_t pending_chars[$];
    int        errors;
    int        chars_seen;
    int        words_noted;
    int        kind_hits[4];

    function new();
      errors      = 0;
      chars_seen  = 0;
      words_noted = 0;
      foreach (kind_hits[k]) kind_hits[k] = 0;
    endfunction

    // predicted character string of one accepted word
    function void note_request(logic [1:0] kind, logic [63:0] value,
                               logic [5:0] width, logic zpad);
      logic [7:0] digs[$];
      fmt_char_t  word_chars[$];
      fmt_char_t  c;
      logic [63:0] mag;
      logic [63:0] rem;
      logic [3:0]  nib;
      logic [7:0]  pad_ch;
      int          cols;
      int          i;
      cols = (width > MAX_W) ? MAX_W : int'(width);
      mag  = value;
      c.last = 1'b0;
      if (kind == KIND_SDEC && value[63]) begin
        c.ch = CHR_MINUS;
        word_chars.push_back(c);
        if (cols > 0) cols--;
        mag = 64'd0 - value;
      end
      if (kind == KIND_HEXLO || kind == KIND_HEXUP) begin
        do begin
          nib = mag[3:0];
          if (nib < 4'd10) digs.push_back(CHR_ZERO + {4'd0, nib});
          else if (kind == KIND_HEXUP) digs.push_back(CHR_UP_A + {4'd0, nib - 4'd10});
          else digs.push_back(CHR_LO_A + {4'd0, nib - 4'd10});
          mag = mag >> 4;
        end while (mag != 64'd0);
      end else begin
        do begin
          rem = mag % 64'd10;
          digs.push_back(CHR_ZERO + rem[7:0]);
          mag = mag / 64'd10;
        end while (mag != 64'd0);
      end
      pad_ch = zpad ? CHR_ZERO : CHR_SPACE;
      for (i = digs.size(); i < cols; i++) begin
        c.ch = pad_ch;
        word_chars.push_back(c);
      end
      for (i = digs.size() - 1; i >= 0; i--) begin
        c.ch = digs[i];
        word_chars.push_back(c);
      end
      word_chars[word_chars.size() - 1].last = 1'b1;
      foreach (word_chars[j]) pending_chars.push_back(word_chars[j]);
      words_noted++;
      kind_hits[kind]++;
    endfunction

    function void check_char(logic [7:0] ch, logic last);
      fmt_char_t want;
      if (pending_chars.size() == 0) begin
        $error("unexpected character %h (last %b) with nothing pending", ch, last);
        errors++;
        return;
      end
      want = pending_chars.pop_front();
      chars_seen++;
      if (want.ch !== ch) begin
        $error("out_char mismatch: expected %h, got %h", want.ch, ch);
        errors++;
      end
      if (want.last !== last) begin
        $error("out_last mismatch: expected %b, got %b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_req_type = KIND_UDEC;
  logic [63:0] in_value = 64'd0;
  logic [5:0]  in_pad_width = 6'd0;
  logic        in_zero_pad = 1'b0;
  logic        out_valid;
  logic [7:0]  out_char;
  logic        out_last;

  format_checker chk = new();
  int            stall_count = 0;

  always #5 clk = ~clk;

  integer_to_ascii_formatter_core #(
    .MAX_WIDTH(MAX_W)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req_type (in_req_type),
    .in_value    (in_value),
    .in_pad_width(in_pad_width),
    .in_zero_pad (in_zero_pad),
    .out_valid   (out_valid),
    .out_char    (out_char),
    .out_last    (out_last)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid) chk.check_char(out_char, out_last);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_count <= 0;
    end else if (stall_count >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  task automatic send_request(input logic [1:0] kind, input logic [63:0] value,
                              input logic [5:0] width, input logic zpad);
    start        <= 1'b1;
    in_req_type  <= kind;
    in_value     <= value;
    in_pad_width <= width;
    in_zero_pad  <= zpad;
    do @(posedge clk); while (busy !== 1'b0);
    chk.note_request(kind, value, width, zpad);
  endtask

  // sender gap, sometimes right after the block frees up
  task automatic sender_gap();
    int mode;
    mode = $urandom_range(0, 3);
    if (mode == 2) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end else if (mode == 3) begin
      start <= 1'b0;
      @(posedge clk);
      while (busy) @(posedge clk);
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    int sel;
    sel = $urandom_range(0, 9);
    v = {$urandom, $urandom};
    case (sel)
      4, 5: v = 64'($urandom_range(0, 999));
      6: v = 64'd0 - 64'($urandom_range(1, 999));
      7: v = v >> $urandom_range(0, 63);
      8: begin
        case ($urandom_range(0, 6))
          0: v = 64'd0;
          1: v = 64'd1;
          2: v = 64'h8000_0000_0000_0000;
          3: v = 64'h7fff_ffff_ffff_ffff;
          4: v = 64'hffff_ffff_ffff_ffff;
          5: v = 64'd10000000000000000000;
          default: v = 64'd9999999999999999999;
        endcase
      end
      9: v = {1'b1, v[62:0]};
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    int i;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words
    send_request(KIND_UDEC,  64'd0, 6'd0, 1'b0);
    send_request(KIND_SDEC,  64'd0, 6'd5, 1'b1);
    send_request(KIND_HEXLO, 64'd0, 6'd0, 1'b0);
    send_request(KIND_HEXUP, 64'd0, 6'd3, 1'b0);
    send_request(KIND_UDEC,  64'hffff_ffff_ffff_ffff, 6'd0, 1'b0);
    send_request(KIND_SDEC,  64'hffff_ffff_ffff_ffff, 6'd0, 1'b0);
    send_request(KIND_SDEC,  64'h8000_0000_0000_0000, 6'd0, 1'b0);
    send_request(KIND_SDEC,  64'h8000_0000_0000_0000, 6'd30, 1'b1);
    send_request(KIND_SDEC,  64'h8000_0000_0000_0000, 6'd30, 1'b0);
    send_request(KIND_SDEC,  64'h7fff_ffff_ffff_ffff, 6'd25, 1'b1);
    send_request(KIND_SDEC,  64'd0 - 64'd42, 6'd8, 1'b0);
    send_request(KIND_SDEC,  64'd0 - 64'd42, 6'd8, 1'b1);
    send_request(KIND_SDEC,  64'd0 - 64'd7, 6'd1, 1'b0);
    send_request(KIND_HEXLO, 64'hdead_beef_cafe_f00d, 6'd0, 1'b0);
    send_request(KIND_HEXUP, 64'hdead_beef_cafe_f00d, 6'd20, 1'b1);
    send_request(KIND_HEXUP, 64'hffff_ffff_ffff_ffff, 6'd63, 1'b0);
    send_request(KIND_UDEC,  64'd12345, 6'd63, 1'b1);
    send_request(KIND_UDEC,  64'd12345, 6'd40, 1'b0);
    send_request(KIND_UDEC,  64'd12345, 6'd41, 1'b1);
    send_request(KIND_UDEC,  64'd987654321, 6'd3, 1'b1);
    send_request(KIND_SDEC,  64'd0 - 64'd1, 6'd63, 1'b1);
    send_request(KIND_HEXLO, 64'h0123_4567_89ab_cdef, 6'd17, 1'b0);

    // random words, gaps only in the first part
    for (i = 0; i < RANDOM_WORDS; i++) begin
      logic [5:0] w;
      if (i < RANDOM_WORDS - CALM_WORDS) sender_gap();
      w = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                      : 6'($urandom_range(0, 24));
      send_request(2'($urandom_range(0, 3)), pick_value(), w, 1'($urandom_range(0, 1)));
    end

    start <= 1'b0;
    while (chk.pending_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d words sent, %0d characters checked", chk.words_noted, chk.chars_seen);
    $display("udec/sdec/hex lower/hex upper words: %0d/%0d/%0d/%0d",
             chk.kind_hits[0], chk.kind_hits[1], chk.kind_hits[2], chk.kind_hits[3]);
    if (chk.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
